FILE: rtl/i2a_pkg.sv
// shared types, codes and character tables of the integer to ascii formatter
package i2a_pkg;

    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_HEXL = 3'd2;
    localparam logic [2:0] KIND_HEXU = 3'd3;
    localparam logic [2:0] KIND_PTR  = 3'd4;

    localparam int BIN_W    = 32;
    localparam int BCD_DIGS = 10;
    localparam int BCD_W    = 4 * BCD_DIGS;

    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;

    localparam logic [7:0] LOWER_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [7:0] UPPER_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_PRE  = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic             load;
        logic [BIN_W-1:0] bin;
    } t_dab_ctrl;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (upper) begin
            c = UPPER_DIGITS[d];
        end else begin
            c = LOWER_DIGITS[d];
        end
        return c;
    endfunction

endpackage

FILE: rtl/i2a_dabble.sv
// iterative binary to bcd converter, one shift-add-3 step per cycle
module i2a_dabble
    import i2a_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dab_ctrl        i_ctrl,
    output logic             o_done,
    output logic [BCD_W-1:0] o_bcd
);

    localparam int CNT_W = $clog2(BIN_W + 1);

    logic [BIN_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [CNT_W-1:0] r_cnt;
    logic [BCD_W-1:0] w_adj;

    always_comb begin
        for (int i = 0; i < BCD_DIGS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.load) begin
            r_cnt <= CNT_W'(BIN_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bin <= i_ctrl.bin;
            r_bcd <= '0;
        end else if (r_cnt != '0) begin
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[BIN_W-1]};
            r_bin <= {r_bin[BIN_W-2:0], 1'b0};
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_bcd  = r_bcd;

endmodule

FILE: rtl/integer_to_ascii_formatter_core.sv
// top level: sequencer, digit buffer and output register of the formatter
//
// Takes one number and a format kind per input word and sends its ascii text
// one character per output word, most significant digit first, with no
// leading zeros and tlast on the final character. Decimal kinds first run a
// shift-add-3 converter over the low 32 bits of the value; then every kind
// skips its leading zero digits one at a time and emits one character at a
// time, waiting while the output register holds a character not yet taken.
// Input is taken only while the sequencer is idle; the last character may
// still wait in the output register then. Kind codes 5 to 7 are taken and
// dropped without output.
module integer_to_ascii_formatter_core
    import i2a_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // value
    input  logic [2:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // char_code, chars_total
    output logic        m_axis_tlast   // last_char
);

    t_state      r_state, n_state;
    logic [63:0] r_digits, n_digits;
    logic [3:0]  r_idx, n_idx;
    logic [1:0]  r_pre_cnt, n_pre_cnt;
    logic        r_upper, n_upper;
    logic        r_ptr, n_ptr;
    logic [31:0] r_count, n_count;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_char, n_out_char;
    logic        r_out_last, n_out_last;
    logic [31:0] r_out_total, n_out_total;

    t_dab_ctrl        w_dab;
    logic             w_dab_done;
    logic [BCD_W-1:0] w_bcd;
    logic [3:0]       w_nib;
    logic             w_out_free;
    logic             w_load;
    logic [31:0]      w_low;

    i2a_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_dab),
        .o_done  (w_dab_done),
        .o_bcd   (w_bcd)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_low         = s_axis_tdata[31:0];
    assign w_nib         = r_digits[{r_idx, 2'b00} +: 4];
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_digits    = r_digits;
        n_idx       = r_idx;
        n_pre_cnt   = r_pre_cnt;
        n_upper     = r_upper;
        n_ptr       = r_ptr;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_load      = 1'b0;
        w_dab.load  = 1'b0;
        w_dab.bin   = w_low;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_upper   = 1'b0;
                    n_ptr     = 1'b0;
                    n_pre_cnt = 2'd0;
                    unique case (s_axis_tuser)
                        KIND_SDEC: begin
                            w_dab.load = 1'b1;
                            w_dab.bin  = w_low[31] ? 32'(~w_low + 32'd1) : w_low;
                            n_pre_cnt  = {1'b0, w_low[31]};
                            n_idx      = 4'(BCD_DIGS - 1);
                            n_state    = ST_CONV;
                        end
                        KIND_UDEC: begin
                            w_dab.load = 1'b1;
                            n_idx      = 4'(BCD_DIGS - 1);
                            n_state    = ST_CONV;
                        end
                        KIND_HEXL, KIND_HEXU: begin
                            n_digits = {32'd0, w_low};
                            n_idx    = 4'd7;
                            n_upper  = (s_axis_tuser == KIND_HEXU);
                            n_state  = ST_SKIP;
                        end
                        KIND_PTR: begin
                            n_digits  = s_axis_tdata;
                            n_idx     = 4'd15;
                            n_pre_cnt = 2'd2;
                            n_ptr     = 1'b1;
                            n_state   = ST_SKIP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                if (w_dab_done) begin
                    n_digits = {(64 - BCD_W)'(0), w_bcd};
                    n_state  = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (r_idx != 4'd0 && w_nib == 4'd0) begin
                    n_idx = r_idx - 4'd1;
                end else if (r_pre_cnt != 2'd0) begin
                    n_state = ST_PRE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_PRE: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    n_out_last = 1'b0;
                    if (r_ptr) begin
                        n_out_char = (r_pre_cnt == 2'd2) ? CHAR_ZERO : CHAR_X;
                    end else begin
                        n_out_char = CHAR_MINUS;
                    end
                    n_pre_cnt = r_pre_cnt - 2'd1;
                    if (r_pre_cnt == 2'd1) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    n_out_char = digit_char(w_nib, r_upper);
                    n_out_last = (r_idx == 4'd0);
                    if (r_idx == 4'd0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 4'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_out_total = r_out_total;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_count     = r_count + 32'd1;
            n_out_total = r_count + 32'd1;
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits    <= n_digits;
        r_idx       <= n_idx;
        r_pre_cnt   <= n_pre_cnt;
        r_upper     <= n_upper;
        r_ptr       <= n_ptr;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_total <= n_out_total;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_total, r_out_char};
    assign m_axis_tlast  = r_out_last;

endmodule
